>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// switched off while reset is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge outside reset.
`define LFP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("lfp assertion failed");

// When the antecedent holds, the consequent must hold at the next sampled edge.
`define LFP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lfp assertion failed");

`endif

>>> rtl/core/lfp_pkg.sv
// ---------------------------------------------------------------------------
// lfp_pkg
// Types and constants shared by the rangefinder frame parser.
// ---------------------------------------------------------------------------
package lfp_pkg;

   localparam logic [7:0] HEADER_BYTE = 8'h59;

   // Byte positions within a nine-byte frame
   localparam logic [3:0] POS_HDR0     = 4'd0;
   localparam logic [3:0] POS_HDR1     = 4'd1;
   localparam logic [3:0] POS_DIST_LO  = 4'd2;
   localparam logic [3:0] POS_DIST_HI  = 4'd3;
   localparam logic [3:0] POS_STR_LO   = 4'd4;
   localparam logic [3:0] POS_STR_HI   = 4'd5;
   localparam logic [3:0] CHECKSUM_POS = 4'd8;

   // Configuration register indexes
   localparam logic [1:0] CSR_MIN_STRENGTH  = 2'd0;
   localparam logic [1:0] CSR_OVEREXPOSURE  = 2'd1;
   localparam logic [1:0] CSR_FAR_THRESHOLD = 2'd2;
   localparam logic [1:0] CSR_NEAR_THRESH   = 2'd3;

   localparam logic [15:0] MIN_STRENGTH_RST  = 16'd100;
   localparam logic [15:0] OVEREXPOSURE_RST  = 16'd65535;
   localparam logic [15:0] FAR_THRESHOLD_RST = 16'd100;
   localparam logic [15:0] NEAR_THRESH_RST   = 16'd50;

   typedef enum logic [1:0] {
      ZONE_FAR      = 2'd0,
      ZONE_MIDDLE   = 2'd1,
      ZONE_NEAR     = 2'd2,
      ZONE_NOT_CONF = 2'd3
   } zone_type;

   typedef struct packed {
      logic [15:0] min_strength;
      logic [15:0] overexposure_code;
      logic [15:0] far_threshold;
      logic [15:0] near_threshold;
   } cfg_type;

   typedef struct packed {
      logic        frame_ok;
      logic [15:0] distance;
      logic [15:0] strength;
      logic        confident;
      zone_type    zone;
   } result_type;

endpackage

>>> rtl/core/lfp_req_if.sv
// ---------------------------------------------------------------------------
// lfp_req_if
// Received-byte channel with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface lfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

>>> rtl/core/lfp_rsp_if.sv
// ---------------------------------------------------------------------------
// lfp_rsp_if
// Parsed frame result channel with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface lfp_rsp_if;
   logic        valid;
   logic        ready;
   logic        frame_ok;
   logic [15:0] distance;
   logic [15:0] strength;
   logic        confident;
   logic [1:0]  zone;

   modport source (output valid, output frame_ok, output distance, output strength,
                   output confident, output zone, input ready);
   modport sink (input valid, input frame_ok, input distance, input strength,
                 input confident, input zone, output ready);
endinterface

>>> rtl/core/lfp_result_calc.sv
// ---------------------------------------------------------------------------
// lfp_result_calc
// Checksum verdict, confidence flag and distance zone for a completed frame.
// ---------------------------------------------------------------------------
module lfp_result_calc (
   input  logic [7:0]          running_sum,
   input  logic [7:0]          checksum_byte,
   input  logic [15:0]         distance_latch,
   input  logic [15:0]         strength_latch,
   input  lfp_pkg::cfg_type    cfg,
   output lfp_pkg::result_type result
);

   logic        ok;
   logic [15:0] dist_val;
   logic [15:0] str;
   logic        conf;

   always_comb begin
      ok       = (running_sum == checksum_byte);
      // A failed frame reports zero readings.
      dist_val = ok ? distance_latch : 16'd0;
      str      = ok ? strength_latch : 16'd0;
      conf     = ok && (str >= cfg.min_strength) && (str != cfg.overexposure_code);

      result.frame_ok  = ok;
      result.distance  = dist_val;
      result.strength  = str;
      result.confident = conf;
      // The far test wins when the thresholds overlap.
      if (!conf) begin
         result.zone = lfp_pkg::ZONE_NOT_CONF;
      end else if (dist_val >= cfg.far_threshold) begin
         result.zone = lfp_pkg::ZONE_FAR;
      end else if (dist_val > cfg.near_threshold) begin
         result.zone = lfp_pkg::ZONE_MIDDLE;
      end else begin
         result.zone = lfp_pkg::ZONE_NEAR;
      end
   end

endmodule

>>> rtl/core/lidar_frame_parser.sv
// ---------------------------------------------------------------------------
// lidar_frame_parser
// Nine-byte rangefinder frame parser with confidence and zone classification.
// ---------------------------------------------------------------------------
// Usage: received serial bytes enter on req_chan, one per transfer. Each frame
// is two 0x59 header bytes, distance and strength (little endian), two spare
// bytes and a checksum byte. A wrong header byte is dropped and the frame
// search starts again with the following byte. The ninth byte of a frame
// produces one transfer on rsp_chan carrying the checksum verdict, readings,
// confidence flag and zone; all other bytes produce nothing.
// Timing: a byte is held in the input register and processed at the edge that
// empties it; the result of the checksum byte is then held in the result register,
// which drives rsp_chan valid. One byte per cycle is accepted continuously
// as long as the result register, the only limit, does not stall. If rsp_chan
// stalls, the result is held and bytes keep flowing until a second checksum
// byte reaches the input register, which then waits. Reset clears the frame
// count, the checksum and both handshakes and loads the default thresholds.
// The user must write the csr_ port only while idle; it is not enforced.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lidar_frame_parser (
   input  logic              clock,
   input  logic              reset,
   lfp_req_if.sink           req_chan,
   lfp_rsp_if.source         rsp_chan,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   lfp_pkg::cfg_type    cfg_ff;
   logic                in_v_ff, in_v_in;
   logic [7:0]          in_byte_ff;
   logic [3:0]          bytes_ff, bytes_in;
   logic [7:0]          sum_ff, sum_in;
   logic [15:0]         dist_ff, dist_in;
   logic [15:0]         str_ff, str_in;
   logic                out_v_ff, out_v_in;
   lfp_pkg::result_type out_ff;
   lfp_pkg::result_type calc_result;
   logic                at_check;
   logic                advance;
   logic                req_xfer;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_strength      <= lfp_pkg::MIN_STRENGTH_RST;
         cfg_ff.overexposure_code <= lfp_pkg::OVEREXPOSURE_RST;
         cfg_ff.far_threshold     <= lfp_pkg::FAR_THRESHOLD_RST;
         cfg_ff.near_threshold    <= lfp_pkg::NEAR_THRESH_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            lfp_pkg::CSR_MIN_STRENGTH:  cfg_ff.min_strength      <= csr_wdata;
            lfp_pkg::CSR_OVEREXPOSURE:  cfg_ff.overexposure_code <= csr_wdata;
            lfp_pkg::CSR_FAR_THRESHOLD: cfg_ff.far_threshold     <= csr_wdata;
            lfp_pkg::CSR_NEAR_THRESH:   cfg_ff.near_threshold    <= csr_wdata;
            default: ;
         endcase
      end
   end

   lfp_result_calc u_calc (
      .running_sum    (sum_ff),
      .checksum_byte  (in_byte_ff),
      .distance_latch (dist_ff),
      .strength_latch (str_ff),
      .cfg            (cfg_ff),
      .result         (calc_result)
   );

   // A byte in the input register moves on unless it must write a result
   // while the result register is still full and stalled.
   assign at_check       = (bytes_ff >= lfp_pkg::CHECKSUM_POS);
   assign advance        = in_v_ff && (!at_check || !out_v_ff || rsp_chan.ready);
   assign req_chan.ready = !in_v_ff || advance;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_v_in = in_v_ff;
      if (req_xfer) begin
         in_v_in = 1'b1;
      end else if (advance) begin
         in_v_in = 1'b0;
      end
   end

   // Frame state update
   always_comb begin
      bytes_in = bytes_ff;
      sum_in   = sum_ff;
      dist_in  = dist_ff;
      str_in   = str_ff;
      if (advance) begin
         if (at_check) begin
            bytes_in = 4'd0;
            sum_in   = 8'd0;
         end else if ((bytes_ff inside {lfp_pkg::POS_HDR0, lfp_pkg::POS_HDR1}) &&
                      (in_byte_ff != lfp_pkg::HEADER_BYTE)) begin
            bytes_in = 4'd0;
            sum_in   = 8'd0;
         end else begin
            case (bytes_ff)
               lfp_pkg::POS_DIST_LO: dist_in = {dist_ff[15:8], in_byte_ff};
               lfp_pkg::POS_DIST_HI: dist_in = {in_byte_ff, dist_ff[7:0]};
               lfp_pkg::POS_STR_LO:  str_in  = {str_ff[15:8], in_byte_ff};
               lfp_pkg::POS_STR_HI:  str_in  = {in_byte_ff, str_ff[7:0]};
               default: ;
            endcase
            sum_in   = sum_ff + in_byte_ff;
            bytes_in = bytes_ff + 4'd1;
         end
      end
   end

   always_comb begin
      out_v_in = out_v_ff && !rsp_chan.ready;
      if (advance && at_check) begin
         out_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         bytes_ff <= 4'd0;
         sum_ff   <= 8'd0;
         dist_ff  <= 16'd0;
         str_ff   <= 16'd0;
      end else begin
         in_v_ff  <= in_v_in;
         out_v_ff <= out_v_in;
         bytes_ff <= bytes_in;
         sum_ff   <= sum_in;
         dist_ff  <= dist_in;
         str_ff   <= str_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_chan.rx_byte;
      end
      if (advance && at_check) begin
         out_ff <= calc_result;
      end
   end

   assign rsp_chan.valid     = out_v_ff;
   assign rsp_chan.frame_ok  = out_ff.frame_ok;
   assign rsp_chan.distance  = out_ff.distance;
   assign rsp_chan.strength  = out_ff.strength;
   assign rsp_chan.confident = out_ff.confident;
   assign rsp_chan.zone      = out_ff.zone;

   `LFP_ASSERT(a_count_range, clock, reset, bytes_ff <= lfp_pkg::CHECKSUM_POS)
   `LFP_ASSERT(a_new_result_restarts, clock, reset, $rose(out_v_ff) |-> (bytes_ff == 4'd0))
   `LFP_ASSERT_NEXT(a_bad_header_restart, clock, reset,
      advance && (bytes_ff <= lfp_pkg::POS_HDR1) && (in_byte_ff != lfp_pkg::HEADER_BYTE),
      (bytes_ff == 4'd0) && (sum_ff == 8'd0))
   `LFP_ASSERT(a_conf_zone, clock, reset,
      out_v_ff |-> (out_ff.confident == (out_ff.zone != lfp_pkg::ZONE_NOT_CONF)))
   `LFP_ASSERT(a_bad_frame_zero, clock, reset,
      (out_v_ff && !out_ff.frame_ok) |-> ((out_ff.distance == 16'd0) &&
         (out_ff.strength == 16'd0) && !out_ff.confident))

endmodule
